### rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants, codes, command and status types and helper functions
// for the buddy page allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int POOL_PAGES = 1024;
  localparam int TOP_ORDER  = 10;
  localparam int PAGE_W     = 10;
  localparam int CNT_W      = 11;
  localparam int LVL_W      = 4;
  localparam int WORD_W     = 32;
  localparam int TREE_WORDS = 68;
  localparam int ADDR_W     = 7;

  // opcodes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REBUILD = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // memory address select
  localparam logic [1:0] AS_NODE  = 2'd0;
  localparam logic [1:0] AS_SCAN  = 2'd1;
  localparam logic [1:0] AS_SWEEP = 2'd2;

  // memory write modes
  localparam logic [2:0] WM_NONE    = 3'd0;
  localparam logic [2:0] WM_ZERO    = 3'd1;
  localparam logic [2:0] WM_SET     = 3'd2;
  localparam logic [2:0] WM_CLR     = 3'd3;
  localparam logic [2:0] WM_CLR_HIT = 3'd4;

  // level register operations
  localparam logic [2:0] LV_HOLD  = 3'd0;
  localparam logic [2:0] LV_ORD   = 3'd1;
  localparam logic [2:0] LV_ZERO  = 3'd2;
  localparam logic [2:0] LV_INC   = 3'd3;
  localparam logic [2:0] LV_DEC   = 3'd4;
  localparam logic [2:0] LV_BUILD = 3'd5;

  // position register operations
  localparam logic [2:0] PS_HOLD = 3'd0;
  localparam logic [2:0] PS_ZERO = 3'd1;
  localparam logic [2:0] PS_PIDX = 3'd2;
  localparam logic [2:0] PS_HIT  = 3'd3;
  localparam logic [2:0] PS_ADD  = 3'd4;

  // word counter operations
  localparam logic [1:0] WC_HOLD = 2'd0;
  localparam logic [1:0] WC_ZERO = 2'd1;
  localparam logic [1:0] WC_INC  = 2'd2;

  // free total operations
  localparam logic [2:0] TT_HOLD  = 3'd0;
  localparam logic [2:0] TT_ALLOC = 3'd1;
  localparam logic [2:0] TT_FREE  = 3'd2;
  localparam logic [2:0] TT_BUILD = 3'd3;

  typedef struct packed {
    logic       ld_req;
    logic       mem_rd;
    logic [1:0] addr_sel;
    logic [2:0] wr_mode;
    logic       buddy;
    logic [2:0] lvl_op;
    logic [2:0] pos_op;
    logic [1:0] wc_op;
    logic [2:0] tot_op;
    logic       bld_start;
    logic       res_ld;
    logic [1:0] res_status;
    logic       res_blk;
    logic       res_grant;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       n_zero;
    logic       ord_big;
    logic       ord_zero;
    logic       misfit;
    logic       alloc_hit;
    logic       alloc_last;
    logic       desc_hit;
    logic       desc_last;
    logic       own_set;
    logic       buddy_set;
    logic       lvl_top;
    logic       lvl_at_ord;
    logic       lvl_next_ord;
    logic       sweep_last;
    logic       build_more;
    logic       out_free;
  } sts_t;

  // smallest order whose block holds n pages
  function automatic logic [LVL_W-1:0] order_of(input logic [CNT_W-1:0] n);
    logic [LVL_W-1:0] o;
    o = '0;
    for (int i = 0; i < 12; i++) begin
      if ((12'd1 << i) < {1'b0, n}) o = LVL_W'(i + 1);
    end
    return o;
  endfunction

  // first tree word of each level
  function automatic logic [ADDR_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
    logic [ADDR_W-1:0] b;
    case (lvl)
      4'd0:    b = 7'd0;
      4'd1:    b = 7'd32;
      4'd2:    b = 7'd48;
      4'd3:    b = 7'd56;
      4'd4:    b = 7'd60;
      4'd5:    b = 7'd62;
      4'd6:    b = 7'd63;
      4'd7:    b = 7'd64;
      4'd8:    b = 7'd65;
      4'd9:    b = 7'd66;
      4'd10:   b = 7'd67;
      default: b = 7'd0;
    endcase
    return b;
  endfunction

  // index of the last tree word of a level
  function automatic logic [4:0] level_last(input logic [LVL_W-1:0] lvl);
    logic [4:0] r;
    r = (lvl <= 4'd5) ? (5'd31 >> lvl) : 5'd0;
    return r;
  endfunction

  function automatic logic [4:0] ctz32(input logic [WORD_W-1:0] w);
    logic [4:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) r = 5'(i);
    end
    return r;
  endfunction

  // trailing zeros of a page address, top order for address zero
  function automatic logic [LVL_W-1:0] ctz_page(input logic [PAGE_W-1:0] p);
    logic [LVL_W-1:0] r;
    r = LVL_W'(TOP_ORDER);
    for (int i = PAGE_W - 1; i >= 0; i--) begin
      if (p[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] flog2(input logic [CNT_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

endpackage

### rtl/core/bpa_req_if.sv
// ----------------------------------------------------------------------------
// bpa_req_if
// request channel: opcode, page count and page index with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [CNT_W-1:0]  page_count;
  logic [PAGE_W-1:0] page_index;

  modport source (output valid, opcode, page_count, page_index, input ready);
  modport sink   (input valid, opcode, page_count, page_index, output ready);
endinterface

### rtl/core/bpa_rsp_if.sv
// ----------------------------------------------------------------------------
// bpa_rsp_if
// response channel: status, block index, granted pages, free count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bpa_rsp_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [PAGE_W-1:0] block_index;
  logic [CNT_W-1:0]  granted_pages;
  logic [CNT_W-1:0]  free_count;

  modport source (output valid, status, block_index, granted_pages, free_count,
                  input ready);
  modport sink   (input valid, status, block_index, granted_pages, free_count,
                  output ready);
endinterface

### rtl/core/bpa_datapath.sv
// ----------------------------------------------------------------------------
// bpa_datapath
// free-bit tree memory, request registers, counters and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_datapath import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic [1:0]        req_opcode,
  input  logic [CNT_W-1:0]  req_page_count,
  input  logic [PAGE_W-1:0] req_page_index,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              rsp_ready,
  output logic              rsp_valid,
  output logic [1:0]        rsp_status,
  output logic [PAGE_W-1:0] rsp_block_index,
  output logic [CNT_W-1:0]  rsp_granted_pages,
  output logic [CNT_W-1:0]  rsp_free_count
);

  logic [WORD_W-1:0] mem [TREE_WORDS];
  logic [WORD_W-1:0] rdata;

  logic [CNT_W-1:0]  usable;
  logic [CNT_W-1:0]  managed;
  logic [CNT_W-1:0]  total;
  logic [1:0]        op;
  logic [LVL_W-1:0]  ord;
  logic              n_zero;
  logic [PAGE_W-1:0] pidx;
  logic [LVL_W-1:0]  lvl;
  logic [CNT_W-1:0]  pos;
  logic [ADDR_W-1:0] wc;
  logic [1:0]        res_status;
  logic              res_blk;
  logic              res_grant;

  logic [CNT_W-1:0]  size;
  logic [CNT_W-1:0]  size_m1;
  logic [CNT_W-1:0]  lim;
  logic [PAGE_W-1:0] node;
  logic [PAGE_W-1:0] nodeb;
  logic [4:0]        bitsel;
  logic [4:0]        hit;
  logic [PAGE_W-1:0] hit_idx;
  logic [ADDR_W-1:0] addr;
  logic [WORD_W-1:0] wdata;
  logic              we;
  logic [LVL_W-1:0]  sh;
  logic [5:0]        cnt;
  logic [WORD_W-1:0] dmask;
  logic [4:0]        desc_last_w;
  logic [LVL_W-1:0]  bld_lvl;
  logic [LVL_W-1:0]  ctz_lvl;
  logic [LVL_W-1:0]  fit_lvl;

  assign size    = CNT_W'(1) << ord;
  assign size_m1 = size - CNT_W'(1);
  assign lim     = (usable > CNT_W'(POOL_PAGES)) ? CNT_W'(POOL_PAGES) : usable;
  assign node    = pos[PAGE_W-1:0] >> lvl;
  assign nodeb   = node ^ PAGE_W'(1);
  assign bitsel  = cmd.buddy ? nodeb[4:0] : node[4:0];
  assign hit     = ctz32(rdata);
  assign hit_idx = {wc[4:0], hit};

  // address and write data of the single memory port
  always_comb begin
    case (cmd.addr_sel)
      AS_NODE:  addr = level_base(lvl) + ADDR_W'(node[9:5]);
      AS_SCAN:  addr = level_base(lvl) + ADDR_W'(node[9:5]) + ADDR_W'(wc[4:0]);
      AS_SWEEP: addr = wc;
      default:  addr = wc;
    endcase
  end

  always_comb begin
    we = 1'b1;
    case (cmd.wr_mode)
      WM_ZERO:    wdata = '0;
      WM_SET:     wdata = rdata | (WORD_W'(1) << bitsel);
      WM_CLR:     wdata = rdata & ~(WORD_W'(1) << bitsel);
      WM_CLR_HIT: wdata = rdata & ~(WORD_W'(1) << hit);
      default: begin
        wdata = rdata;
        we    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (cmd.mem_rd) rdata <= mem[addr];
  end

  // descendant range of a free request on the current lower level
  assign sh          = ord - lvl;
  assign cnt         = 6'(1) << sh;
  assign dmask       = (sh >= 4'd5) ? '1 :
                       (((WORD_W'(1) << cnt) - WORD_W'(1)) << node[4:0]);
  assign desc_last_w = (sh >= 4'd5) ? 5'((6'd1 << (sh - 4'd5)) - 6'd1) : 5'd0;

  // largest aligned block that fits at the build position
  assign ctz_lvl = ctz_page(pos[PAGE_W-1:0]);
  assign fit_lvl = flog2(managed - pos);
  assign bld_lvl = (ctz_lvl < fit_lvl) ? ctz_lvl : fit_lvl;

  always_comb begin
    sts.op           = op;
    sts.n_zero       = n_zero;
    sts.ord_big      = ord > LVL_W'(TOP_ORDER);
    sts.ord_zero     = ord == '0;
    sts.misfit       = ((CNT_W'(pidx) & size_m1) != '0) ||
                       ((CNT_W'(pidx) + size) > managed);
    sts.alloc_hit    = rdata != '0;
    sts.alloc_last   = wc[4:0] == level_last(lvl);
    sts.desc_hit     = (rdata & dmask) != '0;
    sts.desc_last    = wc[4:0] == desc_last_w;
    sts.own_set      = rdata[node[4:0]];
    sts.buddy_set    = rdata[nodeb[4:0]];
    sts.lvl_top      = lvl == LVL_W'(TOP_ORDER);
    sts.lvl_at_ord   = lvl == ord;
    sts.lvl_next_ord = (lvl + LVL_W'(1)) == ord;
    sts.sweep_last   = wc == ADDR_W'(TREE_WORDS - 1);
    sts.build_more   = pos < managed;
    sts.out_free     = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      usable    <= CNT_W'(POOL_PAGES);
      wc        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) usable <= cfg_wr_data;

      case (cmd.wc_op)
        WC_ZERO: wc <= '0;
        WC_INC:  wc <= wc + ADDR_W'(1);
        default: wc <= wc;
      endcase

      if (cmd.out_ld)     rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      op     <= req_opcode;
      ord    <= order_of(req_page_count);
      n_zero <= req_page_count == '0;
      pidx   <= req_page_index;
    end

    case (cmd.lvl_op)
      LV_ORD:   lvl <= ord;
      LV_ZERO:  lvl <= '0;
      LV_INC:   lvl <= lvl + LVL_W'(1);
      LV_DEC:   lvl <= lvl - LVL_W'(1);
      LV_BUILD: lvl <= bld_lvl;
      default:  lvl <= lvl;
    endcase

    if (cmd.bld_start) begin
      pos     <= '0;
      managed <= lim;
    end else begin
      case (cmd.pos_op)
        PS_ZERO: pos <= '0;
        PS_PIDX: pos <= CNT_W'(pidx);
        PS_HIT:  pos <= {1'b0, hit_idx << lvl};
        PS_ADD:  pos <= pos + (CNT_W'(1) << lvl);
        default: pos <= pos;
      endcase
    end

    if (cmd.bld_start) begin
      total <= '0;
    end else begin
      case (cmd.tot_op)
        TT_ALLOC: total <= total - size;
        TT_FREE:  total <= total + size;
        TT_BUILD: total <= total + (CNT_W'(1) << lvl);
        default:  total <= total;
      endcase
    end

    if (cmd.res_ld) begin
      res_status <= cmd.res_status;
      res_blk    <= cmd.res_blk;
      res_grant  <= cmd.res_grant;
    end

    if (cmd.out_ld) begin
      rsp_status        <= res_status;
      rsp_block_index   <= res_blk ? pos[PAGE_W-1:0] : '0;
      rsp_granted_pages <= res_grant ? size : '0;
      rsp_free_count    <= total;
    end
  end

endmodule

### rtl/core/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// sequencer for search, split, free check, coalesce and pool rebuild
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_ctrl import bpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DEC  = 5'd1;
  localparam logic [4:0] S_ARD  = 5'd2;
  localparam logic [4:0] S_ACHK = 5'd3;
  localparam logic [4:0] S_SRD  = 5'd4;
  localparam logic [4:0] S_SWR  = 5'd5;
  localparam logic [4:0] S_FRD  = 5'd6;
  localparam logic [4:0] S_FCHK = 5'd7;
  localparam logic [4:0] S_DRD  = 5'd8;
  localparam logic [4:0] S_DCHK = 5'd9;
  localparam logic [4:0] S_CRD  = 5'd10;
  localparam logic [4:0] S_CCHK = 5'd11;
  localparam logic [4:0] S_SWP  = 5'd12;
  localparam logic [4:0] S_BSEL = 5'd13;
  localparam logic [4:0] S_BRD  = 5'd14;
  localparam logic [4:0] S_BWR  = 5'd15;
  localparam logic [4:0] S_FIN  = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       reply;
  logic       reply_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWP;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

  assign req_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    reply_next = reply;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.ld_req = 1'b1;
          reply_next = 1'b1;
          state_next = S_DEC;
        end
      end

      S_DEC: begin
        case (sts.op)
          OP_ALLOC: begin
            if (sts.n_zero || sts.ord_big) begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = sts.n_zero ? ST_BAD : ST_NOMEM;
              state_next     = S_FIN;
            end else begin
              cmd.lvl_op = LV_ORD;
              cmd.pos_op = PS_ZERO;
              cmd.wc_op  = WC_ZERO;
              state_next = S_ARD;
            end
          end
          OP_FREE: begin
            if (sts.n_zero || sts.ord_big || sts.misfit) begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = ST_BAD;
              state_next     = S_FIN;
            end else begin
              cmd.lvl_op = LV_ORD;
              cmd.pos_op = PS_PIDX;
              state_next = S_FRD;
            end
          end
          OP_REBUILD: begin
            cmd.wc_op  = WC_ZERO;
            state_next = S_SWP;
          end
          default: begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = ST_BAD;
            state_next     = S_FIN;
          end
        endcase
      end

      S_ARD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = AS_SCAN;
        state_next   = S_ACHK;
      end

      S_ACHK: begin
        if (sts.alloc_hit) begin
          cmd.addr_sel = AS_SCAN;
          cmd.wr_mode  = WM_CLR_HIT;
          cmd.pos_op   = PS_HIT;
          if (sts.lvl_at_ord) begin
            cmd.tot_op     = TT_ALLOC;
            cmd.res_ld     = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_blk    = 1'b1;
            cmd.res_grant  = 1'b1;
            state_next     = S_FIN;
          end else begin
            cmd.lvl_op = LV_DEC;
            state_next = S_SRD;
          end
        end else if (sts.alloc_last) begin
          if (sts.lvl_top) begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = ST_NOMEM;
            state_next     = S_FIN;
          end else begin
            cmd.lvl_op = LV_INC;
            cmd.wc_op  = WC_ZERO;
            state_next = S_ARD;
          end
        end else begin
          cmd.wc_op  = WC_INC;
          state_next = S_ARD;
        end
      end

      S_SRD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = AS_NODE;
        cmd.buddy    = 1'b1;
        state_next   = S_SWR;
      end

      S_SWR: begin
        cmd.addr_sel = AS_NODE;
        cmd.buddy    = 1'b1;
        cmd.wr_mode  = WM_SET;
        if (sts.lvl_at_ord) begin
          cmd.tot_op     = TT_ALLOC;
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_blk    = 1'b1;
          cmd.res_grant  = 1'b1;
          state_next     = S_FIN;
        end else begin
          cmd.lvl_op = LV_DEC;
          state_next = S_SRD;
        end
      end

      S_FRD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = AS_NODE;
        state_next   = S_FCHK;
      end

      S_FCHK: begin
        if (sts.own_set) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_BAD;
          state_next     = S_FIN;
        end else if (sts.lvl_top) begin
          if (sts.ord_zero) begin
            cmd.lvl_op = LV_ORD;
            state_next = S_CRD;
          end else begin
            cmd.lvl_op = LV_ZERO;
            cmd.wc_op  = WC_ZERO;
            state_next = S_DRD;
          end
        end else begin
          cmd.lvl_op = LV_INC;
          state_next = S_FRD;
        end
      end

      S_DRD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = AS_SCAN;
        state_next   = S_DCHK;
      end

      S_DCHK: begin
        if (sts.desc_hit) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_BAD;
          state_next     = S_FIN;
        end else if (sts.desc_last) begin
          if (sts.lvl_next_ord) begin
            cmd.lvl_op = LV_ORD;
            state_next = S_CRD;
          end else begin
            cmd.lvl_op = LV_INC;
            cmd.wc_op  = WC_ZERO;
            state_next = S_DRD;
          end
        end else begin
          cmd.wc_op  = WC_INC;
          state_next = S_DRD;
        end
      end

      S_CRD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = AS_NODE;
        state_next   = S_CCHK;
      end

      S_CCHK: begin
        cmd.addr_sel = AS_NODE;
        if (!sts.lvl_top && sts.buddy_set) begin
          cmd.buddy   = 1'b1;
          cmd.wr_mode = WM_CLR;
          cmd.lvl_op  = LV_INC;
          state_next  = S_CRD;
        end else begin
          cmd.wr_mode    = WM_SET;
          cmd.tot_op     = TT_FREE;
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_grant  = 1'b1;
          state_next     = S_FIN;
        end
      end

      S_SWP: begin
        cmd.addr_sel = AS_SWEEP;
        cmd.wr_mode  = WM_ZERO;
        if (sts.sweep_last) begin
          cmd.bld_start = 1'b1;
          state_next    = S_BSEL;
        end else begin
          cmd.wc_op = WC_INC;
        end
      end

      S_BSEL: begin
        if (sts.build_more) begin
          cmd.lvl_op = LV_BUILD;
          state_next = S_BRD;
        end else if (reply) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_FIN;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_BRD: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = AS_NODE;
        state_next   = S_BWR;
      end

      S_BWR: begin
        cmd.addr_sel = AS_NODE;
        cmd.wr_mode  = WM_SET;
        cmd.pos_op   = PS_ADD;
        cmd.tot_op   = TT_BUILD;
        state_next   = S_BSEL;
      end

      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator: one request in flight; the next request is taken once
// the response is loaded
// the single-port free-bit tree memory paces the work: searches, free checks,
// splits and coalesces read a word in one state and check or write it in a second
// reset clears all 68 tree words and rebuilds 1024 pages, ready held low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buddy_page_allocator import bpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  bpa_req_if.sink          req,
  bpa_rsp_if.source        rsp
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: accepts one transaction at a time, walks tree levels
  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: tree memory, counters, free total and the result register,
  // which holds a finished transaction while the next request is taken
  bpa_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .req_opcode        (req.opcode),
    .req_page_count    (req.page_count),
    .req_page_index    (req.page_index),
    .cmd               (cmd),
    .sts               (sts),
    .rsp_ready         (rsp.ready),
    .rsp_valid         (rsp.valid),
    .rsp_status        (rsp.status),
    .rsp_block_index   (rsp.block_index),
    .rsp_granted_pages (rsp.granted_pages),
    .rsp_free_count    (rsp.free_count)
  );

  // one request in flight: ready drops right after an accepted transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

  // free total never exceeds the pool
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.free_count <= CNT_W'(POOL_PAGES)))
    else $error("free count beyond pool");

  // a granted size is a power of two
  a_grant_pow2: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.granted_pages != '0)) |-> $onehot(rsp.granted_pages))
    else $error("granted size not a power of two");

  // a granted block is aligned to its size
  a_grant_align: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.granted_pages != '0)) |->
      ((CNT_W'(rsp.block_index) & (rsp.granted_pages - CNT_W'(1))) == '0))
    else $error("granted block misaligned");

endmodule
